// ----- hdl/lpna_pkg.sv -----
`default_nettype none
package lpna_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_COPY   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSIZE = 2'd1;
  localparam logic [1:0] ST_ZERONAL = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic [2:0] ADDR_CODEC = 3'd0;
  localparam logic [2:0] ADDR_LEN   = 3'd4;

  localparam logic [7:0] AVC_TYPE_MASK  = 8'h1f;
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h7e;
  localparam logic [7:0] AVC_AUD_TYPE   = 8'h09;
  localparam logic [7:0] HEVC_AUD_TYPE  = 8'h46;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef logic [2:0] kind_t;

  localparam kind_t K_AUD_AVC  = 3'd0;
  localparam kind_t K_AUD_HEVC = 3'd1;
  localparam kind_t K_SC4      = 3'd2;
  localparam kind_t K_SC3      = 3'd3;
  localparam kind_t K_BYTE     = 3'd4;
  localparam kind_t K_STATUS   = 3'd5;
  localparam kind_t K_FLUSH    = 3'd6;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] pad;
    logic [1:0]  status;
  } cmd_t;

  function automatic logic [2:0] burst_len(kind_t k);
    logic [2:0] n;
    unique case (k)
      K_AUD_AVC:  n = 3'd6;
      K_AUD_HEVC: n = 3'd7;
      K_SC4:      n = 3'd5;
      K_SC3:      n = 3'd4;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] burst_byte(kind_t k, logic [2:0] idx, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      K_AUD_AVC: begin
        unique case (idx)
          3'd3:    r = 8'h01;
          3'd4:    r = 8'h09;
          3'd5:    r = 8'hf0;
          default: r = 8'h00;
        endcase
      end
      K_AUD_HEVC: begin
        unique case (idx)
          3'd3:    r = 8'h01;
          3'd4:    r = 8'h46;
          3'd5:    r = 8'h01;
          3'd6:    r = 8'h50;
          default: r = 8'h00;
        endcase
      end
      K_SC4: begin
        unique case (idx)
          3'd3:    r = 8'h01;
          3'd4:    r = b;
          default: r = 8'h00;
        endcase
      end
      K_SC3: begin
        unique case (idx)
          3'd2:    r = 8'h01;
          3'd3:    r = b;
          default: r = 8'h00;
        endcase
      end
      K_BYTE:  r = b;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/length_prefixed_nal_to_annexb.sv -----
// path: an input transfer goes through the command queue, then the output register
// throughput: one input transfer per cycle while the 4-entry command queue has room
// output: one result per cycle unless stalled; AUD 6 or 7 bytes, nal start 4 or 5
// the output port sets the sustained rate during start-code bursts
// reset: synchronous, clears parser, queue and output; codec_mode 0, length_field_bytes 4
`default_nettype none
module length_prefixed_nal_to_annexb #(
  parameter int FRAME_SIZE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  data_byte,
  input  wire logic [23:0] frame_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic [23:0]      pad_count,
  output logic             frame_end,
  output logic [1:0]       status,
  output logic             last
);
  import lpna_pkg::*;

  logic       codec_mode;
  logic [2:0] length_field_bytes;
  logic       wr_en;
  logic       q_push;
  cmd_t       q_wcmd;
  logic       q_full;
  logic       q_pop;
  cmd_t       q_head;
  logic       q_empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode         <= 1'b0;
      length_field_bytes <= 3'd4;
    end else if (wr_en) begin
      if (paddr == ADDR_CODEC) begin
        codec_mode <= pwdata[0];
      end else if (paddr == ADDR_LEN) begin
        length_field_bytes <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr == ADDR_CODEC) begin
      prdata = {31'd0, codec_mode};
    end else if (paddr == ADDR_LEN) begin
      prdata = {29'd0, length_field_bytes};
    end else begin
      prdata = 32'd0;
    end
  end

  lpna_front #(
    .FRAME_SIZE_BITS(FRAME_SIZE_BITS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .codec_mode         (codec_mode),
    .length_field_bytes (length_field_bytes),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .op                 (op),
    .data_byte          (data_byte),
    .frame_size         (frame_size),
    .q_push             (q_push),
    .q_cmd              (q_wcmd),
    .q_full             (q_full)
  );

  lpna_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  lpna_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .pad_count  (pad_count),
    .frame_end  (frame_end),
    .status     (status),
    .last       (last)
  );

endmodule
`default_nettype wire

// ----- hdl/lpna_front.sv -----
`default_nettype none
module lpna_front #(
  parameter int FRAME_SIZE_BITS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         codec_mode,
  input  wire logic [2:0]   length_field_bytes,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   op,
  input  wire logic [7:0]   data_byte,
  input  wire logic [23:0]  frame_size,
  output logic              q_push,
  output lpna_pkg::cmd_t    q_cmd,
  input  wire logic         q_full
);
  import lpna_pkg::*;

  localparam int FBL_W = FRAME_SIZE_BITS + 2;

  logic [1:0]       phase, phase_next;
  logic             first, first_next;
  logic [2:0]       lbl, lbl_next;
  logic [31:0]      nbl, nbl_next;
  logic [FBL_W-1:0] fbl, fbl_next;
  logic             err, err_next;
  logic [1:0]       ecode, ecode_next;

  logic                       accept;
  logic [2:0]                 plen;
  logic [FRAME_SIZE_BITS+23:0] fs_wide;
  logic [FRAME_SIZE_BITS-1:0] fs_lim;
  logic                       bad_size;
  logic                       is_delim;
  logic [2:0]                 dec;
  logic                       body;
  logic [FBL_W:0]             diff;
  logic [FBL_W+23:0]          fbl_ext;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (length_field_bytes == 3'd0) begin
      plen = 3'd1;
    end else if (length_field_bytes > 3'd4) begin
      plen = 3'd4;
    end else begin
      plen = length_field_bytes;
    end
  end

  assign fs_wide  = {{FRAME_SIZE_BITS{1'b0}}, frame_size};
  assign fs_lim   = fs_wide[FRAME_SIZE_BITS-1:0];
  assign bad_size = (fs_lim != '0) && (fs_lim[FRAME_SIZE_BITS-1:3] == '0)
                    && (fs_lim[2:0] <= plen);
  assign is_delim = codec_mode ? ((data_byte & HEVC_TYPE_MASK) == HEVC_AUD_TYPE)
                               : ((data_byte & AVC_TYPE_MASK) == AVC_AUD_TYPE);
  assign fbl_ext  = {{24{1'b0}}, fbl};
  assign diff     = {fbl[FBL_W-1], fbl} - {{(FBL_W-2){1'b0}}, dec};

  always_comb begin
    phase_next = phase;
    first_next = first;
    lbl_next   = lbl;
    nbl_next   = nbl;
    fbl_next   = fbl;
    err_next   = err;
    ecode_next = ecode;
    q_push     = 1'b0;
    q_cmd      = '0;
    dec        = 3'd0;
    body       = 1'b0;
    if (accept) begin
      unique case (op)
        OP_START: begin
          first_next = 1'b1;
          phase_next = PH_LENGTH;
          lbl_next   = plen;
          nbl_next   = '0;
          fbl_next   = {2'b00, fs_lim};
          q_push     = 1'b1;
          if (bad_size) begin
            err_next     = 1'b1;
            ecode_next   = ST_BADSIZE;
            q_cmd.kind   = K_STATUS;
            q_cmd.status = ST_BADSIZE;
          end else begin
            err_next   = 1'b0;
            ecode_next = ST_OK;
            q_cmd.kind = codec_mode ? K_AUD_HEVC : K_AUD_AVC;
          end
        end
        OP_DATA: begin
          if (!err) begin
            if (phase == PH_LENGTH) begin
              if (lbl != 3'd0) begin
                nbl_next = {nbl[23:0], data_byte};
                lbl_next = lbl - 3'd1;
              end else if (nbl == '0) begin
                err_next     = 1'b1;
                ecode_next   = ST_ZERONAL;
                q_push       = 1'b1;
                q_cmd.kind   = K_STATUS;
                q_cmd.status = ST_ZERONAL;
              end else if (is_delim) begin
                phase_next = PH_SKIP;
                body       = 1'b1;
              end else begin
                first_next = 1'b0;
                q_push     = 1'b1;
                q_cmd.kind = first ? K_SC4 : K_SC3;
                q_cmd.data = data_byte;
                dec        = first ? 3'd5 : 3'd4;
                phase_next = PH_COPY;
                body       = 1'b1;
              end
            end else if (phase == PH_COPY) begin
              q_push     = 1'b1;
              q_cmd.kind = K_BYTE;
              q_cmd.data = data_byte;
              dec        = 3'd1;
              body       = 1'b1;
            end else if (phase == PH_SKIP) begin
              body = 1'b1;
            end
            if (body) begin
              if (nbl == 32'd1) begin
                phase_next = PH_LENGTH;
                lbl_next   = plen;
                nbl_next   = '0;
              end else begin
                nbl_next = nbl - 32'd1;
              end
            end
            if (dec != 3'd0) begin
              if (diff[FBL_W] && !diff[FBL_W-1]) begin
                fbl_next = {1'b1, {(FBL_W-1){1'b0}}};
              end else begin
                fbl_next = diff[FBL_W-1:0];
              end
            end
          end
        end
        OP_FLUSH: begin
          q_push     = 1'b1;
          q_cmd.kind = K_FLUSH;
          if (err) begin
            q_cmd.status = ecode;
          end else if (plen == 3'd4) begin
            if (fbl[FBL_W-1]) begin
              err_next     = 1'b1;
              ecode_next   = ST_OVERRUN;
              q_cmd.status = ST_OVERRUN;
            end else begin
              q_cmd.pad = fbl_ext[23:0];
              fbl_next  = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LENGTH;
      first <= 1'b1;
      lbl   <= 3'd0;
      nbl   <= '0;
      fbl   <= '0;
      err   <= 1'b0;
      ecode <= ST_OK;
    end else begin
      phase <= phase_next;
      first <= first_next;
      lbl   <= lbl_next;
      nbl   <= nbl_next;
      fbl   <= fbl_next;
      err   <= err_next;
      ecode <= ecode_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpna_fifo.sv -----
`default_nettype none
module lpna_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lpna_pkg::cmd_t wdata,
  output logic                full,
  input  wire logic           pop,
  output lpna_pkg::cmd_t      rdata,
  output logic                empty
);
  import lpna_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpna_back.sv -----
`default_nettype none
module lpna_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lpna_pkg::cmd_t head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic [23:0]         pad_count,
  output logic                frame_end,
  output logic [1:0]          status,
  output logic                last
);
  import lpna_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       final_one;
  logic       is_stream;

  assign load      = !q_empty && (!out_valid || !out_stall);
  assign final_one = (idx == burst_len(head.kind) - 3'd1);
  assign q_pop     = load && final_one;
  assign is_stream = (head.kind != K_STATUS) && (head.kind != K_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_one ? 3'd0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= burst_byte(head.kind, idx, head.data);
      byte_valid <= is_stream;
      pad_count  <= head.pad;
      frame_end  <= (head.kind == K_FLUSH);
      status     <= head.status;
      last       <= final_one;
    end
  end

endmodule
`default_nettype wire

// ----- tb/length_prefixed_nal_to_annexb_test.sv -----
`default_nettype none
module length_prefixed_nal_to_annexb_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpna_pkg::*;

  localparam int FRAME_SIZE_BITS = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 14;
  localparam int RANDOM_PHASES = 9;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint COUNT_FLOOR = -(longint'(1) << (FRAME_SIZE_BITS + 1));
  localparam logic [47:0] AVC_AUD_BYTES = 48'h00_00_00_01_09_f0;
  localparam logic [55:0] HEVC_AUD_BYTES = 56'h00_00_00_01_46_01_50;

  typedef struct packed {
    logic [7:0]  ob;
    logic        bv;
    logic [23:0] pad;
    logic        fend;
    logic [1:0]  st;
    logic        lst;
  } annexb_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  b;
    logic [23:0] fs;
    bit          hold;
  } nal_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [1:0]  op = OP_START;
  logic [7:0]  data_byte = '0;
  logic [23:0] frame_size = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [7:0]  out_byte;
  wire         byte_valid;
  wire  [23:0] pad_count;
  wire         frame_end;
  wire  [1:0]  status;
  wire         last;

  length_prefixed_nal_to_annexb #(.FRAME_SIZE_BITS(FRAME_SIZE_BITS)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .data_byte(data_byte), .frame_size(frame_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .pad_count(pad_count),
    .frame_end(frame_end), .status(status), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nal_item_t      item_queue [$];
  annexb_result_t stream_due [$];
  bit             idle_on = 1'b1;
  int             phase_count = 0;
  int             mismatches = 0;

  // converter model state
  bit          cfg_hevc = 1'b0;
  logic [2:0]  cfg_len = 3'd4;
  logic [1:0]  parse_ph = PH_LENGTH;
  bit          first_nal = 1'b1;
  logic [2:0]  len_left = '0;
  logic [31:0] nal_left = '0;
  longint      frame_left = 0;
  bit          err_on = 1'b0;
  logic [1:0]  err_st = ST_OK;

  function automatic int unsigned prefix_bytes();
    if (cfg_len < 3'd1) return 1;
    if (cfg_len > 3'd4) return 4;
    return cfg_len;
  endfunction

  function automatic void take_bytes(int n);
    frame_left -= n;
    if (frame_left < COUNT_FLOOR) frame_left = COUNT_FLOOR;
  endfunction

  function automatic void hold_error(logic [1:0] code);
    err_on = 1'b1;
    err_st = code;
  endfunction

  function automatic void new_prefix();
    parse_ph = PH_LENGTH;
    len_left = 3'(prefix_bytes());
    nal_left = '0;
  endfunction

  function automatic void due_byte(logic [7:0] b);
    annexb_result_t r;
    r = '0;
    r.ob = b;
    r.bv = 1'b1;
    r.st = ST_OK;
    stream_due.push_back(r);
  endfunction

  function automatic void due_ctl(logic [23:0] pad, logic fend, logic [1:0] st);
    annexb_result_t r;
    r = '0;
    r.pad = pad;
    r.fend = fend;
    r.st = st;
    stream_due.push_back(r);
  endfunction

  function automatic int convert_data(logic [7:0] b);
    int n;
    logic [7:0] mask;
    logic [7:0] aud;
    n = 0;
    if (err_on) return 0;
    if (parse_ph == PH_LENGTH) begin
      if (len_left != 0) begin
        nal_left = {nal_left[23:0], b};
        len_left = len_left - 3'd1;
        return 0;
      end
      if (nal_left == 0) begin
        hold_error(ST_ZERONAL);
        due_ctl('0, 1'b0, ST_ZERONAL);
        return 1;
      end
      mask = cfg_hevc ? HEVC_TYPE_MASK : AVC_TYPE_MASK;
      aud = cfg_hevc ? HEVC_AUD_TYPE : AVC_AUD_TYPE;
      if ((b & mask) == aud) begin
        parse_ph = PH_SKIP;
      end else begin
        if (first_nal) begin
          first_nal = 1'b0;
          due_byte(8'h00);
          n++;
          take_bytes(4);
        end else begin
          take_bytes(3);
        end
        due_byte(8'h00);
        due_byte(8'h00);
        due_byte(8'h01);
        n += 3;
        parse_ph = PH_COPY;
      end
    end
    if (parse_ph == PH_COPY) begin
      due_byte(b);
      n++;
      take_bytes(1);
    end
    if (parse_ph == PH_COPY || parse_ph == PH_SKIP) begin
      nal_left = nal_left - 32'd1;
      if (nal_left == 0) new_prefix();
    end
    return n;
  endfunction

  function automatic void convert_item(logic [1:0] iop, logic [7:0] b, logic [23:0] fs);
    int n;
    logic [23:0] pad;
    logic [1:0] st;
    annexb_result_t r;
    n = 0;
    case (iop)
      OP_START: begin
        first_nal = 1'b1;
        new_prefix();
        frame_left = fs;
        if (fs != 0 && fs <= prefix_bytes()) begin
          hold_error(ST_BADSIZE);
          due_ctl('0, 1'b0, ST_BADSIZE);
          n = 1;
        end else begin
          err_on = 1'b0;
          err_st = ST_OK;
          if (cfg_hevc) begin
            for (int i = 0; i < 7; i++) due_byte(HEVC_AUD_BYTES[55 - 8*i -: 8]);
            n = 7;
          end else begin
            for (int i = 0; i < 6; i++) due_byte(AVC_AUD_BYTES[47 - 8*i -: 8]);
            n = 6;
          end
        end
      end
      OP_DATA: n = convert_data(b);
      OP_FLUSH: begin
        pad = '0;
        st = ST_OK;
        if (err_on) begin
          st = err_st;
        end else if (prefix_bytes() == 4) begin
          if (frame_left < 0) begin
            hold_error(ST_OVERRUN);
            st = ST_OVERRUN;
          end else begin
            pad = frame_left[23:0];
            frame_left = 0;
          end
        end
        due_ctl(pad, 1'b1, st);
        n = 1;
      end
      default: n = 0;
    endcase
    if (n > 0) begin
      r = stream_due.pop_back();
      r.lst = 1'b1;
      stream_due.push_back(r);
    end
  endfunction

  function automatic string res_text(annexb_result_t r);
    return $sformatf("byte %h valid %b pad %0d end %b status %0d last %b",
                     r.ob, r.bv, r.pad, r.fend, r.st, r.lst);
  endfunction

  function automatic int rand_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // input driver
  int        gap_left = 0;
  nal_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) convert_item(op, data_byte, frame_size);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_queue.size() != 0 &&
                     !(item_queue[0].hold && stream_due.size() != 0)) begin
          next_item = item_queue.pop_front();
          op <= next_item.op;
          data_byte <= next_item.b;
          frame_size <= next_item.fs;
          in_valid <= 1'b1;
          gap_left = rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  int             stall_left = 0;
  annexb_result_t got_res;
  annexb_result_t want_res;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_res = {out_byte, byte_valid, pad_count, frame_end, status, last};
        if (stream_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", res_text(got_res));
        end else begin
          want_res = stream_due.pop_front();
          if (got_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch, expected: %s", res_text(want_res));
              $display("                   actual: %s", res_text(got_res));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = rand_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void send(logic [1:0] o, logic [7:0] b, logic [23:0] fs,
                               bit hold = 1'b0);
    nal_item_t it;
    it.op = o;
    it.b = b;
    it.fs = fs;
    it.hold = hold;
    item_queue.push_back(it);
    if (o != OP_NONE) phase_count++;
  endfunction

  function automatic void add_prefix(int nbytes, int value);
    for (int i = nbytes - 1; i >= 0; i--) send(OP_DATA, 8'(value >> (8*i)), 24'($urandom));
  endfunction

  function automatic logic [7:0] aud_byte();
    logic [7:0] r;
    r = 8'($urandom);
    if (cfg_hevc) return (r & ~HEVC_TYPE_MASK) | HEVC_AUD_TYPE;
    return (r & ~AVC_TYPE_MASK) | AVC_AUD_TYPE;
  endfunction

  function automatic void gen_frame();
    int nal_cnt;
    int plen;
    int total;
    int fs;
    int r;
    int sz [3];
    logic [7:0] b;
    plen = prefix_bytes();
    nal_cnt = $urandom_range(1, 3);
    total = 0;
    for (int i = 0; i < nal_cnt; i++) begin
      sz[i] = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      total += plen + sz[i];
    end
    r = $urandom_range(0, 99);
    if (r < 65) fs = total;
    else if (r < 77) fs = total - $urandom_range(1, 8);
    else if (r < 87) fs = $urandom & 32'h00ff_ffff;
    else if (r < 93) fs = 0;
    else fs = $urandom_range(1, plen);
    if (fs < 0) fs = 0;
    send(OP_START, 8'($urandom), 24'(fs), $urandom_range(0, 9) == 0);
    for (int i = 0; i < nal_cnt; i++) begin
      add_prefix(plen, sz[i]);
      for (int j = 0; j < sz[i]; j++) begin
        b = 8'($urandom);
        if (j == 0 && $urandom_range(0, 4) == 0) b = aud_byte();
        send(OP_DATA, b, 24'($urandom));
      end
    end
    if ($urandom_range(0, 9) != 0) send(OP_FLUSH, 8'($urandom), 24'($urandom));
  endfunction

  function automatic void gen_noise();
    int r;
    int cnt;
    cnt = $urandom_range(1, 4);
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send(OP_DATA, 8'($urandom), 24'($urandom));
      else if (r < 70) send(OP_FLUSH, 8'($urandom), 24'($urandom));
      else if (r < 85) send(OP_START, 8'($urandom), 24'($urandom));
      else send(OP_NONE, 8'($urandom), 24'($urandom));
    end
  endfunction

  task automatic wait_idle();
    while (item_queue.size() != 0 || in_valid || stream_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input bit hevc, input logic [2:0] len);
    apb_write(ADDR_CODEC, {31'd0, hevc});
    cfg_hevc = hevc;
    apb_write(ADDR_LEN, {29'd0, len});
    cfg_len = len;
  endtask

  initial begin
    bit hevc;
    logic [2:0] len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // byte before any frame, bad size, zero-length nal, latched error through flush
    send(OP_DATA, 8'h00, 24'd0);
    send(OP_FLUSH, 8'h00, 24'd0);
    send(OP_START, 8'h00, 24'd3);
    send(OP_FLUSH, 8'h00, 24'd0);
    send(OP_START, 8'hff, 24'hff_ffff, 1'b1);
    add_prefix(4, 2);
    send(OP_DATA, 8'h65, 24'd0);
    send(OP_DATA, 8'hff, 24'd0);
    add_prefix(4, 1);
    send(OP_DATA, 8'he9, 24'd0);
    add_prefix(4, 0);
    send(OP_DATA, 8'h00, 24'd0);
    send(OP_NONE, 8'h5a, 24'h00_0001);
    send(OP_FLUSH, 8'h00, 24'd0);
    wait_idle();

    // hevc with one-byte lengths
    set_config(1'b1, 3'd1);
    send(OP_START, 8'h00, 24'd0);
    add_prefix(1, 1);
    send(OP_DATA, 8'h47, 24'd0);
    add_prefix(1, 2);
    send(OP_DATA, 8'h40, 24'd0);
    send(OP_DATA, 8'h01, 24'd0);
    send(OP_FLUSH, 8'h00, 24'd0);
    send(OP_START, 8'h00, 24'd1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin hevc = 1'b0; len = 3'd2; end
        1: begin hevc = 1'b1; len = 3'd3; end
        2: begin hevc = 1'b0; len = 3'd4; end
        3: begin hevc = 1'b1; len = 3'd4; end
        4: begin hevc = 1'b0; len = 3'd1; end
        5: begin hevc = 1'b0; len = 3'd0; end
        6: begin hevc = 1'b1; len = 3'd7; end
        default: begin
          hevc = 1'($urandom);
          len = 3'($urandom_range(1, 4));
        end
      endcase
      set_config(hevc, len);
      idle_on = (p != 2);
      phase_count = 0;
      while (phase_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) gen_frame();
        else gen_noise();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && stream_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
